FILE: rtl/xrl_pkg.sv
package xrl_pkg;

   localparam int COORD_W   = 4;
   localparam int SIZE_W    = 5;
   localparam int VOL_W     = 32;
   localparam int DIST_W    = 5;
   localparam int PROD_W    = DIST_W + VOL_W;
   localparam int OUT_W     = 48;
   localparam int DIR_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MESH_COLS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LINKS = 2'd2;

   localparam logic [DIR_W-1:0] DIR_EAST = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd1;
   localparam logic [DIR_W-1:0] DIR_WEST = 2'd2;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd3;

   localparam logic OP_ROUTE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [SIZE_W-1:0] MESH_SIZE_RESET = 5'd16;

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
      logic [VOL_W-1:0]   volume;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] hop_volume;
      logic [OUT_W-1:0] running_hops;
      logic [OUT_W-1:0] max_link_load;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] mesh_cols;
      logic [SIZE_W-1:0] mesh_rows;
      logic              track_links;
   } cfg_type;

   // clamped transaction handed from front to back
   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
      logic [SIZE_W-1:0]  rows;
      logic [VOL_W-1:0]   volume;
      logic [PROD_W-1:0]  product;
   } desc_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_SETUP,
      BK_WALK,
      BK_DRAIN,
      BK_FINISH,
      BK_CLEAR
   } back_state_type;

endpackage

FILE: rtl/xrl_if.sv
interface xrl_req_if;
   import xrl_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface xrl_rsp_if;
   import xrl_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/xrl_ram.sv
module xrl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/xrl_front.sv
module xrl_front #(
   parameter int MAX_COLS = 16,
   parameter int MAX_ROWS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xrl_pkg::cfg_type         cfg,
   input  xrl_pkg::back_status_type status,
   xrl_req_if.sink                  req_chan,
   output logic                     q_push,
   output xrl_pkg::desc_type        q_data,
   input  logic                     q_full
);
   import xrl_pkg::*;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int hi);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (int'(v) > hi) begin
         r = SIZE_W'(hi);
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c,
                                                      input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] last;
      last = size - SIZE_W'(1);
      return (SIZE_W'(c) >= size) ? last[COORD_W-1:0] : c;
   endfunction

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic              stg_valid_ff, stg_valid_in;
   desc_type          stg_ff, stg_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [SIZE_W-1:0] cols_c, rows_c;
   desc_type          fresh;
   logic              accept;

   assign req_chan.ready = !status.init_busy && (!stg_valid_ff || !q_full);
   assign accept         = req_chan.valid && req_chan.ready;
   assign q_push         = stg_valid_ff && !q_full;

   always_comb begin
      cols_c        = clamp_size(cfg.mesh_cols, MAX_COLS);
      rows_c        = clamp_size(cfg.mesh_rows, MAX_ROWS);
      fresh.op      = req_chan.payload.op;
      fresh.src_x   = clamp_coord(req_chan.payload.src_x, cols_c);
      fresh.src_y   = clamp_coord(req_chan.payload.src_y, rows_c);
      fresh.dst_x   = clamp_coord(req_chan.payload.dst_x, cols_c);
      fresh.dst_y   = clamp_coord(req_chan.payload.dst_y, rows_c);
      fresh.rows    = rows_c;
      fresh.volume  = req_chan.payload.volume;
      fresh.product = '0;

      stg_valid_in = stg_valid_ff;
      stg_in       = stg_ff;
      dist_in      = dist_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
         stg_in       = fresh;
         dist_in      = DIST_W'(abs_diff(fresh.src_x, fresh.dst_x))
                      + DIST_W'(abs_diff(fresh.src_y, fresh.dst_y));
      end else if (q_push) begin
         stg_valid_in = 1'b0;
      end

      q_data         = stg_ff;
      q_data.product = PROD_W'(dist_ff) * PROD_W'(stg_ff.volume);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff  <= stg_in;
      dist_ff <= dist_in;
   end

endmodule

FILE: rtl/xrl_queue.sv
module xrl_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xrl_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output xrl_pkg::desc_type pop_data,
   output logic              empty
);
   import xrl_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   desc_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/xrl_back.sv
module xrl_back #(
   parameter int MAX_COLS    = 16,
   parameter int MAX_ROWS    = 16,
   parameter int COUNT_WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xrl_pkg::cfg_type         cfg,
   input  logic                     q_empty,
   input  xrl_pkg::desc_type        q_data,
   output logic                     q_pop,
   output xrl_pkg::back_status_type status,
   xrl_rsp_if.source                rsp_chan
);
   import xrl_pkg::*;

   localparam int LINK_DEPTH = MAX_COLS * MAX_ROWS * 4;
   localparam int IDX_W      = $clog2(LINK_DEPTH);
   localparam int NODE_W     = COORD_W + SIZE_W + 1;
   localparam int LIN_W      = NODE_W + DIR_W;
   localparam int HV_W       = (PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH;
   localparam int OW         = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
   localparam logic [COUNT_WIDTH-1:0] CAP      = '1;
   localparam logic [IDX_W-1:0]       CLR_LAST = IDX_W'(LINK_DEPTH - 1);

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? CAP : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_prod(input logic [PROD_W-1:0] p);
      logic [HV_W-1:0] e;
      e = HV_W'(p);
      return (e > HV_W'(CAP)) ? CAP : COUNT_WIDTH'(e);
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
      logic [OW-1:0] e;
      e = OW'(v);
      return (e > OW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(e);
   endfunction

   back_state_type         state_ff, state_in;
   desc_type               cur_ff, cur_in;
   logic [COUNT_WIDTH-1:0] hv_ff, hv_in;
   logic [COUNT_WIDTH-1:0] hop_total_ff, hop_total_in;
   logic [COUNT_WIDTH-1:0] peak_ff, peak_in;
   logic [COORD_W-1:0]     pos_ff, pos_in;
   logic                   phase_y_ff, phase_y_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]       rd_addr_ff, rd_addr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [COORD_W-1:0]     lx, ly, pos_next;
   logic [DIR_W-1:0]       ldir;
   logic                   step_up;
   logic [NODE_W-1:0]      node;
   logic [LIN_W-1:0]       lin;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata, link_sum;
   logic                   rsp_free;

   assign status.init_busy = (state_ff == BK_INIT);
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop            = (state_ff == BK_IDLE) && !q_empty;

   // current link of the walk
   always_comb begin
      lx       = phase_y_ff ? cur_ff.dst_x : pos_ff;
      ly       = phase_y_ff ? pos_ff : cur_ff.src_y;
      step_up  = phase_y_ff ? (cur_ff.dst_y > cur_ff.src_y) : (cur_ff.dst_x > cur_ff.src_x);
      if (phase_y_ff) begin
         ldir = step_up ? DIR_UP : DIR_DOWN;
      end else begin
         ldir = step_up ? DIR_EAST : DIR_WEST;
      end
      pos_next = step_up ? pos_ff + COORD_W'(1) : pos_ff - COORD_W'(1);
      node     = NODE_W'(lx) * NODE_W'(cur_ff.rows) + NODE_W'(ly);
      lin      = {node, ldir};
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      hv_in        = hv_ff;
      hop_total_in = hop_total_ff;
      peak_in      = peak_ff;
      pos_in       = pos_ff;
      phase_y_in   = phase_y_ff;
      clr_in       = clr_ff;
      rd_valid_in  = 1'b0;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      link_sum     = sat_add(ram_rdata, COUNT_WIDTH'(cur_ff.volume));

      case (state_ff)
         BK_INIT, BK_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == CLR_LAST) begin
               clr_in   = '0;
               state_in = (state_ff == BK_INIT) ? BK_IDLE : BK_FINISH;
            end
         end
         BK_IDLE: begin
            if (q_pop) begin
               cur_in = q_data;
               hv_in  = sat_prod(q_data.product);
               if (q_data.op == OP_CLEAR) begin
                  hop_total_in = '0;
                  peak_in      = '0;
                  clr_in       = '0;
                  state_in     = BK_CLEAR;
               end else begin
                  state_in = BK_SETUP;
               end
            end
         end
         BK_SETUP: begin
            hop_total_in = sat_add(hop_total_ff, hv_ff);
            if (!cfg.track_links) begin
               state_in = BK_DRAIN;
            end else if (cur_ff.src_x != cur_ff.dst_x) begin
               phase_y_in = 1'b0;
               pos_in     = cur_ff.src_x;
               state_in   = BK_WALK;
            end else if (cur_ff.src_y != cur_ff.dst_y) begin
               phase_y_in = 1'b1;
               pos_in     = cur_ff.src_y;
               state_in   = BK_WALK;
            end else begin
               state_in = BK_DRAIN;
            end
         end
         BK_WALK: begin
            rd_valid_in = (int'(lin) < LINK_DEPTH);
            rd_addr_in  = IDX_W'(lin);
            pos_in      = pos_next;
            if (!phase_y_ff && pos_next == cur_ff.dst_x) begin
               if (cur_ff.src_y != cur_ff.dst_y) begin
                  phase_y_in = 1'b1;
                  pos_in     = cur_ff.src_y;
               end else begin
                  state_in = BK_DRAIN;
               end
            end else if (phase_y_ff && pos_next == cur_ff.dst_y) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (cur_ff.op == OP_CLEAR) begin
                  rsp_in = '0;
               end else begin
                  rsp_in.hop_volume    = to_out(hv_ff);
                  rsp_in.running_hops  = to_out(hop_total_ff);
                  rsp_in.max_link_load = to_out(peak_ff);
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // read-modify-write of the link read in the previous cycle
      if (rd_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = rd_addr_ff;
         ram_wdata = link_sum;
         if (link_sum > peak_ff) begin
            peak_in = link_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hop_total_ff <= '0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hop_total_ff <= hop_total_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      hv_ff      <= hv_in;
      pos_ff     <= pos_in;
      phase_y_ff <= phase_y_in;
      rd_addr_ff <= rd_addr_in;
      rsp_ff     <= rsp_in;
   end

   xrl_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (LINK_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr_in),
      .rdata (ram_rdata)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   a_rd_from_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff) == BK_WALK)
      else $error("link update without a walk step");

   a_init_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_INIT && clr_ff == CLR_LAST) |=> state_ff == BK_IDLE)
      else $error("init sweep did not end in idle");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR && clr_ff == CLR_LAST) |=> state_ff == BK_FINISH)
      else $error("clear sweep did not end in finish");

   a_peak_mono: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_data.op == OP_CLEAR) |=> peak_ff >= $past(peak_ff))
      else $error("peak load dropped without clear");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_data.op == OP_CLEAR) |=> hop_total_ff >= $past(hop_total_ff))
      else $error("hop total dropped without clear");

endmodule

FILE: rtl/xy_route_link_load.sv
// Flow: a route transaction is registered in the front stage, queued, then taken by the back
// end through SETUP, a WALK over its links when link tracking is on, DRAIN and FINISH; a clear
// instead zeroes all MAX_COLS*MAX_ROWS*4 link entries before FINISH. The back end handles one
// transaction at a time, one link per cycle; the front stage and queue hold further ones.
// Reset: synchronous; after reset a clearing pass over all MAX_COLS*MAX_ROWS*4 entries zeroes
// the link table while req_chan.ready stays low; csr writes are taken throughout.
module xy_route_link_load #(
   parameter int MAX_COLS    = 16,
   parameter int MAX_ROWS    = 16,
   parameter int COUNT_WIDTH = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   xrl_req_if.sink                         req_chan,
   xrl_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [xrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [xrl_pkg::SIZE_W-1:0]      csr_wdata
);
   import xrl_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   back_status_type status;
   desc_type        push_data, pop_data;
   logic            q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MESH_COLS:   cfg_in.mesh_cols   = csr_wdata;
            CSR_MESH_ROWS:   cfg_in.mesh_rows   = csr_wdata;
            CSR_TRACK_LINKS: cfg_in.track_links = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mesh_cols   <= MESH_SIZE_RESET;
         cfg_ff.mesh_rows   <= MESH_SIZE_RESET;
         cfg_ff.track_links <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xrl_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .status   (status),
      .req_chan (req_chan),
      .q_push   (q_push),
      .q_data   (push_data),
      .q_full   (q_full)
   );

   xrl_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   xrl_back #(
      .MAX_COLS    (MAX_COLS),
      .MAX_ROWS    (MAX_ROWS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (pop_data),
      .q_pop    (q_pop),
      .status   (status),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import xrl_pkg::*;

   localparam int GRID_COLS   = 16;
   localparam int GRID_ROWS   = 16;
   localparam int LINK_DEPTH  = GRID_COLS * GRID_ROWS * 4;
   localparam logic [63:0] COUNT_MAX = 64'h0000_FFFF_FFFF_FFFF;
   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 52;
   // full-volume transfers piled onto one link
   localparam int REPEAT_ITEMS = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_XFER, ROW_CSR} row_kind_type;

   typedef struct {
      bit      pinned;
      rsp_type value;
   } pinned_rsp_type;

   typedef struct {
      row_kind_type         kind;
      req_type              xfer;
      bit                   pinned;
      rsp_type              want;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [SIZE_W-1:0]    reg_val;
   } step_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0] csr_wdata;

   xrl_req_if req_chan ();
   xrl_rsp_if rsp_chan ();

   xy_route_link_load dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // link accounting shadow
   logic [OUT_W-1:0]  link_tab [0:LINK_DEPTH-1];
   logic [OUT_W-1:0]  hop_sum;
   logic [OUT_W-1:0]  peak_link;
   logic [SIZE_W-1:0] mesh_cols_m;
   logic [SIZE_W-1:0] mesh_rows_m;
   logic              track_m;

   rsp_type        due_rsp_q [$];
   pinned_rsp_type pinned_q [$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             rsp_hold = 0;
   bit             gaps_on = 1'b1;

   task automatic flag_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > COUNT_MAX) ? COUNT_MAX : s;
   endfunction

   function automatic int mesh_dim(input logic [SIZE_W-1:0] v, input int hi);
      if (v == 0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   function automatic int pin_coord(input logic [COORD_W-1:0] c, input int size);
      return (int'(c) >= size) ? size - 1 : int'(c);
   endfunction

   function automatic void bump_link(input int x, input int y, input logic [DIR_W-1:0] dir,
                                     input int rows, input logic [63:0] vol);
      int idx;
      idx = (x * rows + y) * 4 + int'(dir);
      if (idx < LINK_DEPTH) begin
         link_tab[idx] = OUT_W'(sat_sum(64'(link_tab[idx]), vol));
         if (link_tab[idx] > peak_link) peak_link = link_tab[idx];
      end
   endfunction

   function automatic rsp_type account_transfer(input req_type t);
      int cols, rows, sx, sy, dx, dy, p, span;
      logic [63:0] vol, hv;
      rsp_type r;
      if (t.op == OP_CLEAR) begin
         foreach (link_tab[i]) link_tab[i] = '0;
         hop_sum = '0;
         peak_link = '0;
         return '0;
      end
      cols = mesh_dim(mesh_cols_m, GRID_COLS);
      rows = mesh_dim(mesh_rows_m, GRID_ROWS);
      sx = pin_coord(t.src_x, cols);
      sy = pin_coord(t.src_y, rows);
      dx = pin_coord(t.dst_x, cols);
      dy = pin_coord(t.dst_y, rows);
      vol = 64'(t.volume);
      span = ((dx > sx) ? dx - sx : sx - dx) + ((dy > sy) ? dy - sy : sy - dy);
      hv = 64'(span) * vol;
      if (hv > COUNT_MAX) hv = COUNT_MAX;
      hop_sum = OUT_W'(sat_sum(64'(hop_sum), hv));
      if (track_m) begin
         if (dx > sx) begin
            for (p = sx; p < dx; p++) bump_link(p, sy, DIR_EAST, rows, vol);
         end else begin
            for (p = sx; p > dx; p--) bump_link(p, sy, DIR_WEST, rows, vol);
         end
         if (dy > sy) begin
            for (p = sy; p < dy; p++) bump_link(dx, p, DIR_UP, rows, vol);
         end else begin
            for (p = sy; p > dy; p--) bump_link(dx, p, DIR_DOWN, rows, vol);
         end
      end
      r.hop_volume = hv[OUT_W-1:0];
      r.running_hops = hop_sum;
      r.max_link_load = peak_link;
      return r;
   endfunction

   // shadow update, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      pinned_rsp_type tag;
      rsp_type guess;
      if (reset) begin
         foreach (link_tab[i]) link_tab[i] = '0;
         hop_sum = '0;
         peak_link = '0;
         mesh_cols_m = MESH_SIZE_RESET;
         mesh_rows_m = MESH_SIZE_RESET;
         track_m = 1'b1;
         quiet_cycles = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MESH_COLS: mesh_cols_m = csr_wdata;
               CSR_MESH_ROWS: mesh_rows_m = csr_wdata;
               CSR_TRACK_LINKS: track_m = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (due_rsp_q.size() == 0) begin
               flag_mismatch($sformatf("response with nothing outstanding: %h", got));
            end else begin
               want = due_rsp_q.pop_front();
               if (got.hop_volume !== want.hop_volume)
                  flag_mismatch($sformatf("hop_volume got %h expected %h",
                                          got.hop_volume, want.hop_volume));
               if (got.running_hops !== want.running_hops)
                  flag_mismatch($sformatf("running_hops got %h expected %h",
                                          got.running_hops, want.running_hops));
               if (got.max_link_load !== want.max_link_load)
                  flag_mismatch($sformatf("max_link_load got %h expected %h",
                                          got.max_link_load, want.max_link_load));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            guess = account_transfer(req_chan.payload);
            if (pinned_q.size() != 0) begin
               tag = pinned_q.pop_front();
            end else begin
               tag.pinned = 1'b0;
               tag.value = '0;
            end
            due_rsp_q.insert(due_rsp_q.size(), tag.pinned ? tag.value : guess);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("** xy_route_link_load: FAILED **");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (gaps_on && $urandom_range(0, 3) == 0) rsp_hold <= gap_len();
      end
   end

   // valid stays high on return so back-to-back transactions need no toggle
   task automatic send_xfer(input req_type t, input bit pinned, input rsp_type want);
      int gap;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pinned_q.insert(pinned_q.size(), pinned_rsp_type'{pinned, want});
      req_chan.valid <= 1'b1;
      req_chan.payload <= t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic settle();
      if (req_chan.valid) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      while (due_rsp_q.size() != 0 || pinned_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic step_row_type xfer_row(input logic op,
                                             input int sx, sy, dx, dy,
                                             input logic [VOL_W-1:0] vol);
      step_row_type row;
      row = '{ROW_XFER, '0, 1'b0, '0, '0, '0};
      row.xfer = '{op, COORD_W'(sx), COORD_W'(sy), COORD_W'(dx), COORD_W'(dy), vol};
      return row;
   endfunction

   function automatic step_row_type pin(input step_row_type row,
                                        input logic [OUT_W-1:0] hv, tot, mx);
      row.pinned = 1'b1;
      row.want = '{hv, tot, mx};
      return row;
   endfunction

   function automatic step_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [SIZE_W-1:0] val);
      return '{ROW_CSR, '0, 1'b0, '0, idx, val};
   endfunction

   task automatic run_directed();
      step_row_type plan [$];
      plan.insert(plan.size(),
                  pin(xfer_row(OP_ROUTE, 0, 0, 0, 0, 32'hFFFF_FFFF), '0, '0, '0));
      plan.insert(plan.size(), pin(xfer_row(OP_ROUTE, 0, 0, 15, 15, 32'hFFFF_FFFF),
                  48'h001D_FFFF_FFE2, 48'h001D_FFFF_FFE2, 48'h0000_FFFF_FFFF));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 15, 15, 0, 0, 32'd1));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 3, 4, 9, 4, 32'd100));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 9, 4, 3, 4, 32'd100));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 5, 2, 5, 12, 32'h8000_0000));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 5, 12, 5, 2, 32'h7FFF_FFFF));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 2, 2, 3, 2, 32'hFFFF_FFFF));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 2, 2, 3, 2, 32'hFFFF_FFFF));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 0, 15, 15, 0, 32'd0));
      plan.insert(plan.size(),
                  pin(xfer_row(OP_CLEAR, 15, 15, 15, 15, 32'hFFFF_FFFF), '0, '0, '0));
      plan.insert(plan.size(),
                  pin(xfer_row(OP_ROUTE, 1, 1, 2, 1, 32'd5), 48'd5, 48'd5, 48'd5));
      // coordinates beyond a 4 x 3 mesh
      plan.insert(plan.size(), csr_row(CSR_MESH_COLS, 5'd4));
      plan.insert(plan.size(), csr_row(CSR_MESH_ROWS, 5'd3));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 15, 15, 0, 0, 32'd7));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 0, 0, 9, 9, 32'd3));
      // zero size acts as one
      plan.insert(plan.size(), csr_row(CSR_MESH_COLS, 5'd0));
      plan.insert(plan.size(), csr_row(CSR_MESH_ROWS, 5'd0));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 5, 6, 9, 1, 32'hFFFF_FFFF));
      plan.insert(plan.size(), csr_row(CSR_MESH_COLS, 5'd31));
      plan.insert(plan.size(), csr_row(CSR_MESH_ROWS, 5'd31));
      plan.insert(plan.size(), csr_row(CSR_TRACK_LINKS, 5'b11110));
      plan.insert(plan.size(), xfer_row(OP_ROUTE, 0, 0, 15, 0, 32'd1000));
      plan.insert(plan.size(), csr_row(CSR_TRACK_LINKS, 5'b00001));
      plan.insert(plan.size(),
                  pin(xfer_row(OP_CLEAR, 0, 0, 0, 0, 32'd0), '0, '0, '0));
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            csr_write(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_xfer(plan[i].xfer, plan[i].pinned, plan[i].want);
         end
      end
   endtask

   function automatic req_type rand_xfer();
      req_type t;
      t.op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_ROUTE;
      t.src_x = COORD_W'($urandom_range(0, 15));
      t.src_y = COORD_W'($urandom_range(0, 15));
      t.dst_x = COORD_W'($urandom_range(0, 15));
      t.dst_y = COORD_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
         t.dst_x = t.src_x;
         t.dst_y = t.src_y;
      end
      case ($urandom_range(0, 5))
         0: t.volume = '1;
         1: t.volume = VOL_W'($urandom_range(0, 255));
         2: t.volume = '0;
         default: t.volume = $urandom;
      endcase
      return t;
   endfunction

   task automatic run_random_phases();
      int ph, n;
      logic [SIZE_W-1:0] c, r;
      logic trk;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         case (ph)
            0: begin c = 5'd16; r = 5'd16; end
            1: begin c = 5'd0;  r = 5'd31; end
            2: begin c = 5'd31; r = 5'd0;  end
            3: begin c = 5'd1;  r = 5'd16; end
            4: begin c = 5'd16; r = 5'd1;  end
            default: begin
               c = SIZE_W'($urandom_range(0, 31));
               r = SIZE_W'($urandom_range(0, 31));
            end
         endcase
         trk = (ph == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
         csr_write(CSR_MESH_COLS, c);
         csr_write(CSR_MESH_ROWS, r);
         csr_write(CSR_TRACK_LINKS, {4'($urandom_range(0, 15)), trk});
         if (ph == 2) csr_write(CSR_SPARE, 5'($urandom_range(0, 31)));
         gaps_on = (ph != 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ((ph == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 59) == 0) settle();
            send_xfer(rand_xfer(), 1'b0, '0);
         end
      end
   endtask

   // one link takes repeated full-volume transfers back to back
   task automatic run_hot_link();
      int n;
      settle();
      gaps_on = 1'b0;
      csr_write(CSR_MESH_COLS, 5'd16);
      csr_write(CSR_MESH_ROWS, 5'd16);
      csr_write(CSR_TRACK_LINKS, 5'd1);
      send_xfer('{OP_CLEAR, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0}, 1'b1, '0);
      for (n = 0; n < REPEAT_ITEMS; n++)
         send_xfer('{OP_ROUTE, 4'd2, 4'd3, 4'd3, 4'd3, 32'hFFFF_FFFF}, 1'b0, '0);
      send_xfer('{OP_ROUTE, 4'd0, 4'd3, 4'd15, 4'd15, 32'hFFFF_FFFF}, 1'b0, '0);
      gaps_on = 1'b1;
      send_xfer('{OP_CLEAR, 4'd9, 4'd9, 4'd9, 4'd9, 32'd9}, 1'b1, '0);
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random_phases();
      run_hot_link();
      settle();
      repeat (40) @(posedge clock);
      if (due_rsp_q.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", due_rsp_q.size()));
      if (mismatch_count == 0) begin
         $display("** xy_route_link_load: PASSED **");
      end else begin
         $display("** xy_route_link_load: FAILED **");
      end
      $finish;
   end

endmodule
